[rtl/kmeans_cluster_engine_defines.svh]
// assertion macros for the k-means cluster engine
`ifndef KMEANS_CLUSTER_ENGINE_DEFINES_SVH
`define KMEANS_CLUSTER_ENGINE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define KCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/kce_pkg.sv]
package kce_pkg;

  // data set limits
  localparam int MAX_POINTS   = 64;
  localparam int MAX_CLUSTERS = 8;
  localparam int PT_W         = $clog2(MAX_POINTS);
  localparam int CL_W         = $clog2(MAX_CLUSTERS);
  localparam int STORE_DEPTH  = MAX_POINTS * MAX_CLUSTERS;
  localparam int SA_W         = $clog2(STORE_DEPTH);
  localparam int CENT_DEPTH   = MAX_CLUSTERS * MAX_CLUSTERS;
  localparam int CA_W         = $clog2(CENT_DEPTH);

  // field widths
  localparam int COORD_W = 16;
  localparam int CENT_W  = 32;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 7;

  // divider
  localparam int DIV_W     = 40;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_LIMIT    = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [DIV_W-1:0] quot;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/kmeans_cluster_engine.sv]
// k-means cluster engine
// s_axis carries one signed Q16.0 coordinate per beat, point-major order. The
// beat that completes N*K coordinates starts clustering; s_axis_tready stays
// low until all N result beats have left on m_axis (tlast on the last one).
// cfg_* writes a register by index (0 points, 1 clusters, 2 restarts, 3 seed,
// 4 pass limit); it is always ready and is meant to be used while idle.
// Loading takes one coordinate per cycle. Clustering runs on one shared
// multiplier and one radix-2 divider under a sequencer. Per restart: random
// draws and a clear of the running means; per pass: a copy of the centroids,
// the distance work over every point and centroid, and a mean update for
// each coordinate (two per coordinate for a point that moves). The divider
// and the distance loop set the total. Each result beat is read out and
// registered before it is offered, and the next follows only once the
// receiver has taken it; a stall simply holds the current result.
// Reset returns the block to idle with the register defaults (64 points,
// 2 clusters, 1 restart, seed 1, pass limit 64) and an empty load position.
`include "kmeans_cluster_engine_defines.svh"

module kmeans_cluster_engine (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] coordinate
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [5:0] point_number, [8:6] cluster_label,
                                      // [56:9] best_wcss, [57] pass_limit_hit
  output logic        m_axis_tlast,   // final_result
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RSTART = 5'd1;
  localparam logic [4:0] S_RDRAW  = 5'd2;
  localparam logic [4:0] S_RWAIT  = 5'd3;
  localparam logic [4:0] S_ISCAN  = 5'd4;
  localparam logic [4:0] S_IRD    = 5'd5;
  localparam logic [4:0] S_IWR    = 5'd6;
  localparam logic [4:0] S_ZCLR   = 5'd7;
  localparam logic [4:0] S_DADDR  = 5'd8;
  localparam logic [4:0] S_DDATA  = 5'd9;
  localparam logic [4:0] S_DMUL   = 5'd10;
  localparam logic [4:0] S_DACC   = 5'd11;
  localparam logic [4:0] S_DCMP   = 5'd12;
  localparam logic [4:0] S_PGOT   = 5'd13;
  localparam logic [4:0] S_PMOVE  = 5'd14;
  localparam logic [4:0] S_UADDR  = 5'd15;
  localparam logic [4:0] S_UDATA  = 5'd16;
  localparam logic [4:0] S_UNUM   = 5'd17;
  localparam logic [4:0] S_UDIV   = 5'd18;
  localparam logic [4:0] S_UWAIT  = 5'd19;
  localparam logic [4:0] S_UWR    = 5'd20;
  localparam logic [4:0] S_UEND   = 5'd21;
  localparam logic [4:0] S_PNEXT  = 5'd22;
  localparam logic [4:0] S_CPRD   = 5'd23;
  localparam logic [4:0] S_CPWR   = 5'd24;
  localparam logic [4:0] S_ECHK   = 5'd25;
  localparam logic [4:0] S_BARD   = 5'd26;
  localparam logic [4:0] S_BAWR   = 5'd27;
  localparam logic [4:0] S_ENEXT  = 5'd28;
  localparam logic [4:0] S_ORD    = 5'd29;
  localparam logic [4:0] S_OLD    = 5'd30;
  localparam logic [4:0] S_OWAIT  = 5'd31;

  logic [4:0] state;

  // configuration
  logic [6:0]  point_count;
  logic [3:0]  cluster_count;
  logic [4:0]  restart_count;
  logic [7:0]  pass_limit;
  logic [31:0] rng_word;

  // effective values
  logic [6:0] n_val;
  logic [6:0] nm1;
  logic [3:0] dims_val;
  logic [2:0] dm1;
  logic [3:0] kc_val;
  logic [2:0] kcm1;
  logic [4:0] restarts_val;
  logic [7:0] limit_val;
  logic [10:0] nk;

  // load
  logic [kce_pkg::SA_W-1:0] load_pos;
  logic [kce_pkg::SA_W:0]   pos_inc;
  logic                     in_beat;

  // sequencer registers
  logic                       phase_sweep;
  logic [kce_pkg::PT_W:0]     pi;
  logic [kce_pkg::SA_W-1:0]   pbase;
  logic [kce_pkg::CL_W-1:0]   kk;
  logic [kce_pkg::CL_W-1:0]   cc;
  logic [kce_pkg::CL_W-1:0]   jj;
  logic [3:0]                 ic;
  logic [3:0]                 got;
  logic [kce_pkg::CA_W-1:0]   ix;
  logic [kce_pkg::MAX_POINTS-1:0] picked;
  logic [kce_pkg::SUM_W-1:0]  sacc;
  logic [kce_pkg::SUM_W-1:0]  mind;
  logic [kce_pkg::CL_W-1:0]   best;
  logic [20:0]                aval;
  logic signed [54:0]         prod;
  logic [kce_pkg::CL_W-1:0]   a_reg;
  logic [kce_pkg::CL_W-1:0]   o_reg;
  logic [kce_pkg::CNT_W-1:0]  na_reg;
  logic [kce_pkg::CNT_W-1:0]  no_reg;
  logic                       second;
  logic [kce_pkg::COORD_W-1:0] xreg;
  logic [kce_pkg::DIV_W-1:0]  num;
  logic                       nsign;
  logic [kce_pkg::CENT_W-1:0] qres;
  logic [kce_pkg::SUM_W-1:0]  sum;
  logic                       changes;
  logic [7:0]                 passes;
  logic [4:0]                 rr;
  logic [kce_pkg::SUM_W-1:0]  best_sum;
  logic                       best_hit;
  logic [kce_pkg::CNT_W-1:0]  counts [kce_pkg::MAX_CLUSTERS];

  // output registers
  logic                      out_valid;
  logic [kce_pkg::PT_W-1:0]  out_point;
  logic [kce_pkg::CL_W-1:0]  out_label;
  logic                      out_last;

  // ram ports
  logic [kce_pkg::SA_W-1:0]   pt_raddr;
  logic [kce_pkg::COORD_W-1:0] pt_rdata;
  logic                       cent_we;
  logic [kce_pkg::CA_W-1:0]   cent_waddr;
  logic [kce_pkg::CENT_W-1:0] cent_wdata;
  logic [kce_pkg::CENT_W-1:0] cent_rdata;
  logic                       run_we;
  logic [kce_pkg::CA_W-1:0]   run_waddr;
  logic [kce_pkg::CA_W-1:0]   run_raddr;
  logic [kce_pkg::CENT_W-1:0] run_wdata;
  logic [kce_pkg::CENT_W-1:0] run_rdata;
  logic [kce_pkg::PT_W-1:0]   asg_raddr;
  logic [kce_pkg::CL_W-1:0]   asg_rdata;
  logic [kce_pkg::CL_W-1:0]   best_rdata;

  // datapath helpers
  logic [kce_pkg::CL_W-1:0]   ucl;
  logic [kce_pkg::CL_W-1:0]   cnt_sel;
  logic [kce_pkg::CNT_W-1:0]  cnt_rd;
  logic [31:0]                x0, x1, x2, x3;
  logic signed [32:0]         diff;
  logic [32:0]                absd;
  logic signed [32:0]         mul_x;
  logic signed [21:0]         mul_y;
  logic [kce_pkg::SUM_W:0]    acc_sum;
  logic [kce_pkg::SUM_W:0]    pass_sum;
  logic [kce_pkg::DIV_W-1:0]  xw40;
  logic [kce_pkg::DIV_W-1:0]  mag;
  logic [40:0]                qs41;
  logic                       q_ovf;
  logic [kce_pkg::CENT_W-1:0] qsat;
  logic [7:0]                 passes_inc;

  kce_pkg::div_req_t div_req;
  kce_pkg::div_rsp_t div_rsp;

  // effective register values
  always_comb begin
    if (point_count == 7'd0) begin
      n_val = 7'd1;
    end else if (point_count > 7'(kce_pkg::MAX_POINTS)) begin
      n_val = 7'(kce_pkg::MAX_POINTS);
    end else begin
      n_val = point_count;
    end
    if (cluster_count == 4'd0) begin
      dims_val = 4'd1;
    end else if (cluster_count > 4'(kce_pkg::MAX_CLUSTERS)) begin
      dims_val = 4'(kce_pkg::MAX_CLUSTERS);
    end else begin
      dims_val = cluster_count;
    end
    kc_val       = (n_val < {3'b0, dims_val}) ? n_val[3:0] : dims_val;
    restarts_val = (restart_count == 5'd0) ? 5'd1 : restart_count;
    limit_val    = (pass_limit == 8'd0) ? 8'd1 : pass_limit;
  end

  assign nm1  = n_val - 7'd1;
  assign dm1  = 3'(dims_val - 4'd1);
  assign kcm1 = 3'(kc_val - 4'd1);
  assign nk   = 11'(n_val) * 11'(dims_val);

  // handshakes
  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign pos_inc       = {1'b0, load_pos} + 1'b1;
  assign cfg_ready     = 1'b1;

  // xorshift step
  always_comb begin
    x0 = (rng_word == 32'd0) ? 32'd1 : rng_word;
    x1 = x0 ^ (x0 << 13);
    x2 = x1 ^ (x1 >> 17);
    x3 = x2 ^ (x2 << 5);
  end

  // member count read, one port
  assign cnt_sel = (state == S_PMOVE) ? o_reg : best;
  assign cnt_rd  = counts[cnt_sel];
  assign ucl     = second ? o_reg : a_reg;

  // distance term
  assign diff = {{5{pt_rdata[15]}}, pt_rdata, 12'b0} - {cent_rdata[31], cent_rdata};
  assign absd = diff[32] ? 33'(-diff) : 33'(diff);

  // shared multiplier operands
  always_comb begin
    if (state == S_DMUL) begin
      mul_x = {12'b0, aval};
      mul_y = {1'b0, aval};
    end else begin
      mul_x = {run_rdata[31], run_rdata};
      mul_y = {15'b0, (second ? no_reg : na_reg)};
    end
  end

  assign acc_sum  = {1'b0, sacc} + {1'b0, prod[kce_pkg::SUM_W-1:0]};
  assign pass_sum = {1'b0, sum} + {1'b0, mind};

  // mean update terms
  assign xw40 = {{12{xreg[15]}}, xreg, 12'b0};
  assign mag  = num[kce_pkg::DIV_W-1] ? -num : num;
  assign qs41 = nsign ? -{1'b0, div_rsp.quot} : {1'b0, div_rsp.quot};
  assign q_ovf = !((&qs41[40:31]) || !(|qs41[40:31]));
  assign qsat = q_ovf ? (qs41[40] ? 32'h8000_0000 : 32'h7FFF_FFFF) : qs41[31:0];
  assign passes_inc = passes + 8'd1;

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {8'b0, x3};
    div_req.divisor  = n_val;
    if (state == S_RDRAW && got != kc_val) begin
      div_req.start = 1'b1;
    end else if (state == S_UDIV) begin
      div_req.start    = 1'b1;
      div_req.dividend = mag;
      div_req.divisor  = second ? (no_reg - 7'd1) : (na_reg + 7'd1);
    end
  end

  kce_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // memory addressing
  assign pt_raddr   = pbase + {6'b0, ((state == S_DADDR) ? kk : jj)};
  assign cent_we    = (state == S_IWR) || (state == S_CPWR);
  assign cent_waddr = (state == S_IWR) ? {ic[2:0], jj} : ix;
  assign cent_wdata = (state == S_IWR) ? {{4{pt_rdata[15]}}, pt_rdata, 12'b0} : run_rdata;
  assign run_we     = (state == S_ZCLR) || (state == S_UWR);
  assign run_waddr  = (state == S_ZCLR) ? ix : {ucl, jj};
  assign run_wdata  = (state == S_ZCLR) ? '0 : qres;
  assign run_raddr  = (state == S_CPRD) ? ix : {ucl, jj};
  assign asg_raddr  = (state == S_BARD) ? ix : pi[kce_pkg::PT_W-1:0];

  kce_ram #(.WIDTH(kce_pkg::COORD_W), .DEPTH(kce_pkg::STORE_DEPTH)) u_points (
    .clk   (clk),
    .we    (in_beat),
    .waddr (load_pos),
    .wdata (s_axis_tdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  kce_ram #(.WIDTH(kce_pkg::CENT_W), .DEPTH(kce_pkg::CENT_DEPTH)) u_cent (
    .clk   (clk),
    .we    (cent_we),
    .waddr (cent_waddr),
    .wdata (cent_wdata),
    .raddr ({cc, kk}),
    .rdata (cent_rdata)
  );

  kce_ram #(.WIDTH(kce_pkg::CENT_W), .DEPTH(kce_pkg::CENT_DEPTH)) u_run (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_waddr),
    .wdata (run_wdata),
    .raddr (run_raddr),
    .rdata (run_rdata)
  );

  kce_ram #(.WIDTH(kce_pkg::CL_W), .DEPTH(kce_pkg::MAX_POINTS)) u_asg (
    .clk   (clk),
    .we    (state == S_UEND),
    .waddr (pi[kce_pkg::PT_W-1:0]),
    .wdata (a_reg),
    .raddr (asg_raddr),
    .rdata (asg_rdata)
  );

  kce_ram #(.WIDTH(kce_pkg::CL_W), .DEPTH(kce_pkg::MAX_POINTS)) u_best (
    .clk   (clk),
    .we    (state == S_BAWR),
    .waddr (ix),
    .wdata (asg_rdata),
    .raddr (ix),
    .rdata (best_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_pos      <= '0;
      out_valid     <= 1'b0;
      point_count   <= 7'd64;
      cluster_count <= 4'd2;
      restart_count <= 5'd1;
      pass_limit    <= 8'd64;
      rng_word      <= 32'd1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            if ({1'b0, pos_inc} >= nk) begin
              load_pos <= '0;
              best_sum <= '1;
              best_hit <= 1'b0;
              rr       <= '0;
              state    <= S_RSTART;
            end else begin
              load_pos <= pos_inc[kce_pkg::SA_W-1:0];
            end
          end
        end
        S_RSTART: begin
          picked <= '0;
          got    <= '0;
          for (int i = 0; i < kce_pkg::MAX_CLUSTERS; i++) begin
            counts[i] <= '0;
          end
          state <= S_RDRAW;
        end
        // draw distinct starting points
        S_RDRAW: begin
          if (got == kc_val) begin
            pi    <= '0;
            pbase <= '0;
            ic    <= '0;
            state <= S_ISCAN;
          end else begin
            rng_word <= x3;
            state    <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          if (div_rsp.done) begin
            if (!picked[div_rsp.rem[kce_pkg::PT_W-1:0]]) begin
              picked[div_rsp.rem[kce_pkg::PT_W-1:0]] <= 1'b1;
              got <= got + 4'd1;
            end
            state <= S_RDRAW;
          end
        end
        // picked points become centroids in index order
        S_ISCAN: begin
          if (ic == kc_val || pi == n_val) begin
            ix    <= '0;
            state <= S_ZCLR;
          end else if (picked[pi[kce_pkg::PT_W-1:0]]) begin
            jj    <= '0;
            state <= S_IRD;
          end else begin
            pi    <= pi + 1'b1;
            pbase <= pbase + {5'b0, dims_val};
          end
        end
        S_IRD: state <= S_IWR;
        S_IWR: begin
          if (jj == dm1) begin
            ic    <= ic + 4'd1;
            pi    <= pi + 1'b1;
            pbase <= pbase + {5'b0, dims_val};
            state <= S_ISCAN;
          end else begin
            jj    <= jj + 1'b1;
            state <= S_IRD;
          end
        end
        // clear running means, then first assignment pass
        S_ZCLR: begin
          ix <= ix + 1'b1;
          if (ix == {kce_pkg::CA_W{1'b1}}) begin
            phase_sweep <= 1'b0;
            pi    <= '0;
            pbase <= '0;
            cc    <= '0;
            kk    <= '0;
            sacc  <= '0;
            state <= S_DADDR;
          end
        end
        // distance of one point to one centroid, one coordinate at a time
        S_DADDR: state <= S_DDATA;
        S_DDATA: begin
          aval  <= absd[32:12];
          state <= S_DMUL;
        end
        S_DMUL: begin
          prod  <= mul_x * mul_y;
          state <= S_DACC;
        end
        S_DACC: begin
          sacc <= acc_sum[kce_pkg::SUM_W] ? '1 : acc_sum[kce_pkg::SUM_W-1:0];
          if (kk == dm1) begin
            state <= S_DCMP;
          end else begin
            kk    <= kk + 1'b1;
            state <= S_DADDR;
          end
        end
        S_DCMP: begin
          if (cc == '0 || sacc < mind) begin
            mind <= sacc;
            best <= cc;
          end
          sacc <= '0;
          kk   <= '0;
          if (cc == kcm1) begin
            state <= S_PGOT;
          end else begin
            cc    <= cc + 1'b1;
            state <= S_DADDR;
          end
        end
        // nearest centroid known
        S_PGOT: begin
          na_reg <= cnt_rd;
          a_reg  <= best;
          second <= 1'b0;
          jj     <= '0;
          if (!phase_sweep) begin
            state <= S_UADDR;
          end else begin
            sum   <= pass_sum[kce_pkg::SUM_W] ? '1 : pass_sum[kce_pkg::SUM_W-1:0];
            o_reg <= asg_rdata;
            if (best == asg_rdata) begin
              state <= S_PNEXT;
            end else begin
              changes <= 1'b1;
              state   <= S_PMOVE;
            end
          end
        end
        S_PMOVE: begin
          no_reg <= cnt_rd;
          state  <= S_UADDR;
        end
        // running mean update of one coordinate
        S_UADDR: begin
          if (second && no_reg <= 7'd1) begin
            qres  <= '0;
            state <= S_UWR;
          end else begin
            state <= S_UDATA;
          end
        end
        S_UDATA: begin
          xreg  <= pt_rdata;
          prod  <= mul_x * mul_y;
          state <= S_UNUM;
        end
        S_UNUM: begin
          num   <= second ? (prod[kce_pkg::DIV_W-1:0] - xw40)
                          : (prod[kce_pkg::DIV_W-1:0] + xw40);
          state <= S_UDIV;
        end
        S_UDIV: begin
          nsign <= num[kce_pkg::DIV_W-1];
          state <= S_UWAIT;
        end
        S_UWAIT: begin
          if (div_rsp.done) begin
            qres  <= qsat;
            state <= S_UWR;
          end
        end
        S_UWR: begin
          if (phase_sweep && !second) begin
            second <= 1'b1;
            state  <= S_UADDR;
          end else begin
            second <= 1'b0;
            if (jj == dm1) begin
              state <= S_UEND;
            end else begin
              jj    <= jj + 1'b1;
              state <= S_UADDR;
            end
          end
        end
        S_UEND: begin
          counts[a_reg] <= counts[a_reg] + 7'd1;
          if (phase_sweep && counts[o_reg] != '0) begin
            counts[o_reg] <= counts[o_reg] - 7'd1;
          end
          state <= S_PNEXT;
        end
        S_PNEXT: begin
          if (pi[kce_pkg::PT_W-1:0] == nm1[kce_pkg::PT_W-1:0]) begin
            ix    <= '0;
            state <= S_CPRD;
          end else begin
            pi    <= pi + 1'b1;
            pbase <= pbase + {5'b0, dims_val};
            cc    <= '0;
            kk    <= '0;
            sacc  <= '0;
            state <= S_DADDR;
          end
        end
        // centroids for the next pass
        S_CPRD: state <= S_CPWR;
        S_CPWR: begin
          if (ix == {kce_pkg::CA_W{1'b1}}) begin
            if (!phase_sweep || (changes && passes_inc < limit_val)) begin
              passes      <= phase_sweep ? passes_inc : 8'd0;
              phase_sweep <= 1'b1;
              sum     <= '0;
              changes <= 1'b0;
              pi      <= '0;
              pbase   <= '0;
              cc      <= '0;
              kk      <= '0;
              sacc    <= '0;
              state   <= S_DADDR;
            end else begin
              state <= S_ECHK;
            end
          end else begin
            ix    <= ix + 1'b1;
            state <= S_CPRD;
          end
        end
        // keep the best restart
        S_ECHK: begin
          if (rr == '0 || sum < best_sum) begin
            best_sum <= sum;
            best_hit <= changes;
            ix       <= '0;
            state    <= S_BARD;
          end else begin
            state <= S_ENEXT;
          end
        end
        S_BARD: state <= S_BAWR;
        S_BAWR: begin
          if (ix == nm1[kce_pkg::PT_W-1:0]) begin
            state <= S_ENEXT;
          end else begin
            ix    <= ix + 1'b1;
            state <= S_BARD;
          end
        end
        S_ENEXT: begin
          if (rr + 5'd1 < restarts_val) begin
            rr    <= rr + 5'd1;
            state <= S_RSTART;
          end else begin
            ix    <= '0;
            state <= S_ORD;
          end
        end
        // result beats
        S_ORD: state <= S_OLD;
        S_OLD: begin
          out_point <= ix;
          out_label <= best_rdata;
          out_last  <= (ix == nm1[kce_pkg::PT_W-1:0]);
          out_valid <= 1'b1;
          state     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              ix    <= ix + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          kce_pkg::REG_POINT_COUNT:   point_count   <= cfg_data[6:0];
          kce_pkg::REG_CLUSTER_COUNT: cluster_count <= cfg_data[3:0];
          kce_pkg::REG_RESTART_COUNT: restart_count <= cfg_data[4:0];
          kce_pkg::REG_RNG_SEED:      rng_word      <= cfg_data;
          kce_pkg::REG_PASS_LIMIT:    pass_limit    <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, best_hit, best_sum, out_label, out_point};
  assign m_axis_tlast  = out_last;

  `KCE_ASSERT_NOW(a_ready_no_result, s_axis_tready, !m_axis_tvalid, "input open with a result pending")
  `KCE_ASSERT_NOW(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `KCE_ASSERT_NEXT(a_last_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not idle after final beat")

endmodule

[rtl/kce_ram.sv]
module kce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kce_div.sv]
module kce_div (
  input  logic              clk,
  input  logic              rst,
  input  kce_pkg::div_req_t req,
  output kce_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [kce_pkg::DIV_CNT_W-1:0]     cnt;
  logic [kce_pkg::DIV_W-1:0]         quot;
  logic [kce_pkg::CNT_W-1:0]         rem;
  logic [kce_pkg::CNT_W-1:0]         den;
  logic [kce_pkg::CNT_W:0]           trial;
  logic [kce_pkg::CNT_W:0]           diff;
  logic                              ge;

  // one restoring step per cycle
  assign trial = {rem, quot[kce_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      quot <= req.dividend;
      den  <= req.divisor;
      rem  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= ge ? diff[kce_pkg::CNT_W-1:0] : trial[kce_pkg::CNT_W-1:0];
      quot <= {quot[kce_pkg::DIV_W-2:0], ge};
      cnt  <= cnt + 1'b1;
      if (cnt == kce_pkg::DIV_CNT_W'(kce_pkg::DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

[tb/tb_kmeans_cluster_engine.sv]
`timescale 1ns / 100ps

module tb_kmeans_cluster_engine;
  import kce_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_GOAL     = 360;

  // one pending beat: a coordinate or a register write
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] data;
  } beat_t;

  // one expected result beat
  typedef struct {
    logic [5:0]  pnum;
    logic [2:0]  label;
    logic [47:0] wcss;
    logic        hit;
    logic        last;
  } label_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  beat_t  beat_q[$];
  label_t label_q[$];
  int     errors = 0;
  int     items_queued = 0;
  bit     gaps_on = 1'b1;

  // shadow of the engine state
  shortint         pts[STORE_DEPTH];
  int              cent[CENT_DEPTH];
  int              run_c[CENT_DEPTH];
  int              members[MAX_CLUSTERS];
  int              asg[MAX_POINTS];
  int              best_asg[MAX_POINTS];
  longint unsigned best_sum;
  bit              best_hit;
  int unsigned     rng;
  int unsigned     load_pos;
  int unsigned     r_points, r_clusters, r_restarts, r_seed, r_limit;
  bit              picked[MAX_POINTS];

  kmeans_cluster_engine i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // fixed point helpers
  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint unsigned add48(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'hffff_ffff_ffff) ? 64'hffff_ffff_ffff : s;
  endfunction

  function automatic longint widen(int p, int k, int dims);
    return longint'(pts[(p * dims + k) % STORE_DEPTH]) * 4096;
  endfunction

  function automatic longint unsigned sq_dist(int c, int p, int dims);
    longint unsigned s, a;
    longint d;
    s = 0;
    for (int k = 0; k < dims; k++) begin
      d = widen(p, k, dims) - longint'(cent[c * MAX_CLUSTERS + k]);
      a = (d < 0) ? longint'(-d) : d;
      a = a >> 12;
      s = add48(s, a * a);
    end
    return s;
  endfunction

  // nearest centroid, lowest index on a tie
  function automatic int nearest(int p, int dims, int kc, output longint unsigned dmin);
    int b;
    longint unsigned m, d;
    b = 0;
    m = sq_dist(0, p, dims);
    for (int c = 1; c < kc; c++) begin
      d = sq_dist(c, p, dims);
      if (d < m) begin
        m = d;
        b = c;
      end
    end
    dmin = m;
    return b;
  endfunction

  function automatic int unsigned xorshift_draw();
    int unsigned x;
    x = (rng != 0) ? rng : 1;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    rng = x;
    return x;
  endfunction

  // full clustering over all restarts
  task automatic cluster_points(int n, int dims);
    int kc, restarts, limit, got, passes, changes, c, a, o;
    longint unsigned total, d;
    longint cnt, na, no, x;
    kc = (dims < n) ? dims : n;
    restarts = (r_restarts != 0) ? r_restarts : 1;
    limit = (r_limit != 0) ? r_limit : 1;
    best_sum = 64'hffff_ffff_ffff;
    best_hit = 1'b0;
    for (int r = 0; r < restarts; r++) begin
      got = 0;
      passes = 0;
      foreach (picked[i]) picked[i] = 1'b0;
      while (got < kc) begin
        a = xorshift_draw() % n;
        if (!picked[a]) begin
          picked[a] = 1'b1;
          got++;
        end
      end
      c = 0;
      for (int i = 0; i < n && c < kc; i++) begin
        if (picked[i]) begin
          for (int j = 0; j < dims; j++) cent[c * MAX_CLUSTERS + j] = sat32(widen(i, j, dims));
          c++;
        end
      end
      for (int i = 0; i < n; i++) asg[i] = nearest(i, dims, kc, d);
      foreach (run_c[i]) run_c[i] = 0;
      foreach (members[i]) members[i] = 0;
      for (int i = 0; i < n; i++) begin
        a = asg[i];
        members[a]++;
        cnt = members[a];
        for (int j = 0; j < dims; j++)
          run_c[a * MAX_CLUSTERS + j] =
            sat32(((cnt - 1) * longint'(run_c[a * MAX_CLUSTERS + j]) + widen(i, j, dims)) / cnt);
      end
      cent = run_c;
      // reassignment sweeps
      do begin
        total = 0;
        changes = 0;
        for (int i = 0; i < n; i++) begin
          a = nearest(i, dims, kc, d);
          o = asg[i];
          total = add48(total, d);
          if (a != o) begin
            changes++;
            na = members[a];
            no = members[o];
            for (int j = 0; j < dims; j++) begin
              x = widen(i, j, dims);
              run_c[a * MAX_CLUSTERS + j] =
                sat32((na * longint'(run_c[a * MAX_CLUSTERS + j]) + x) / (na + 1));
              run_c[o * MAX_CLUSTERS + j] = (no <= 1) ? 0 :
                sat32((no * longint'(run_c[o * MAX_CLUSTERS + j]) - x) / (no - 1));
            end
            members[a]++;
            if (members[o] != 0) members[o]--;
            asg[i] = a;
          end
        end
        cent = run_c;
        passes++;
      end while (changes != 0 && passes < limit);
      if (r == 0 || total < best_sum) begin
        best_sum = total;
        best_hit = (changes != 0);
        best_asg = asg;
      end
    end
  endtask

  // accepted coordinate: store it, cluster on the last one
  task automatic load_coordinate(logic [15:0] raw);
    int n, dims;
    label_t e;
    n = (r_points < 1) ? 1 : ((r_points > MAX_POINTS) ? MAX_POINTS : r_points);
    dims = (r_clusters < 1) ? 1 : ((r_clusters > MAX_CLUSTERS) ? MAX_CLUSTERS : r_clusters);
    if (load_pos < STORE_DEPTH) pts[load_pos] = shortint'(raw);
    load_pos++;
    if (load_pos >= n * dims) begin
      load_pos = 0;
      cluster_points(n, dims);
      for (int i = 0; i < n; i++) begin
        e.pnum  = i[5:0];
        e.label = best_asg[i][2:0];
        e.wcss  = best_sum[47:0];
        e.hit   = best_hit;
        e.last  = (i == n - 1);
        label_q.push_back(e);
      end
    end
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_POINT_COUNT:   r_points = data & 32'h7f;
      REG_CLUSTER_COUNT: r_clusters = data & 32'hf;
      REG_RESTART_COUNT: r_restarts = data & 32'h1f;
      REG_RNG_SEED: begin
        r_seed = data;
        rng = data;
      end
      REG_PASS_LIMIT:    r_limit = data & 32'hff;
      default: ;
    endcase
  endtask

  // driver for coordinate and register beats
  int drv_gap = 0;
  int settle = 0;
  always @(posedge clk) begin
    beat_t b;
    bit    busy;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) load_coordinate(s_axis_tdata);
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      settle = (label_q.size() == 0) ? ((settle < 1000) ? settle + 1 : settle) : 0;
      busy = (s_axis_tvalid && !s_axis_tready) || (cfg_valid && !cfg_ready);
      if (!busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
          s_axis_tvalid <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (beat_q.size() != 0 && beat_q[0].is_cfg) begin
          s_axis_tvalid <= 1'b0;
          // register writes only once the engine has gone quiet
          if (settle >= SETTLE_CYCLES && !(s_axis_tvalid && s_axis_tready)) begin
            b = beat_q.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= b.idx;
            cfg_data <= b.data;
            drv_gap = pick_gap();
          end else begin
            cfg_valid <= 1'b0;
          end
        end else if (beat_q.size() != 0) begin
          b = beat_q.pop_front();
          cfg_valid <= 1'b0;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= b.data[15:0];
          drv_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  int stall = 0;
  always @(posedge clk) begin
    label_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (label_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", m_axis_tdata, 0);
        end else begin
          e = label_q.pop_front();
          if (m_axis_tdata[5:0] !== e.pnum)
            report_mismatch("point_number", m_axis_tdata[5:0], e.pnum);
          if (m_axis_tdata[8:6] !== e.label)
            report_mismatch("cluster_label", m_axis_tdata[8:6], e.label);
          if (m_axis_tdata[56:9] !== e.wcss)
            report_mismatch("best_wcss", m_axis_tdata[56:9], e.wcss);
          if (m_axis_tdata[57] !== e.hit)
            report_mismatch("pass_limit_hit", m_axis_tdata[57], e.hit);
          if (m_axis_tlast !== e.last)
            report_mismatch("final_result", m_axis_tlast, e.last);
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic queue_write(logic [2:0] idx, logic [31:0] data);
    beat_t b;
    b.is_cfg = 1'b1;
    b.idx = idx;
    b.data = data;
    beat_q.push_back(b);
  endtask

  task automatic queue_coord(logic [15:0] v);
    beat_t b;
    b.is_cfg = 1'b0;
    b.idx = '0;
    b.data = {16'h0, v};
    beat_q.push_back(b);
    items_queued++;
  endtask

  // data set: grouped points around random centers, or uniform noise
  task automatic queue_data_set(int n, int dims, bit grouped, bit with_extremes);
    int centers[MAX_CLUSTERS][MAX_CLUSTERS];
    int spread, g, v;
    spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(16, 3000);
    foreach (centers[i, j]) centers[i][j] = $urandom_range(0, 56000) - 28000;
    for (int p = 0; p < n; p++) begin
      g = $urandom_range(0, dims - 1);
      for (int k = 0; k < dims; k++) begin
        if (with_extremes && p * dims + k < 4) begin
          case (p * dims + k)
            0: v = 32767;
            1: v = -32768;
            2: v = 0;
            default: v = -1;
          endcase
        end else if (grouped) begin
          v = centers[g][k] + $urandom_range(0, 2 * spread) - spread;
        end else begin
          v = $urandom_range(0, 65535) - 32768;
        end
        queue_coord(v[15:0]);
      end
    end
  endtask

  task automatic queue_all_regs(int n, int k, int r, int seed, int lim);
    queue_write(REG_POINT_COUNT, n);
    queue_write(REG_CLUSTER_COUNT, k);
    queue_write(REG_RESTART_COUNT, r);
    queue_write(REG_RNG_SEED, seed);
    queue_write(REG_PASS_LIMIT, lim);
  endtask

  initial begin
    int n, k;
    r_points = 64;
    r_clusters = 2;
    r_restarts = 1;
    r_seed = 1;
    r_limit = 64;
    rng = 1;
    load_pos = 0;
    best_sum = 64'hffff_ffff_ffff;
    best_hit = 1'b0;

    // reset defaults: 64 points of 2 coordinates, extremes first
    queue_data_set(64, 2, 1'b1, 1'b1);
    // more clusters than points, zero seed, many restarts, pass limit zero
    queue_all_regs(4, 8, 31, 0, 0);
    queue_data_set(4, 8, 1'b1, 1'b0);
    // clamped-low sizes, widest seed, longest pass limit
    queue_all_regs(0, 0, 0, 32'hffff_ffff, 255);
    queue_data_set(1, 1, 1'b0, 1'b0);
    // clamped-high point count, one pass only
    queue_all_regs(127, 1, 16, $urandom, 1);
    queue_data_set(64, 1, 1'b1, 1'b0);
    // clamped-high cluster count
    queue_all_regs(8, 15, 2, $urandom, 3);
    queue_data_set(8, 8, 1'b0, 1'b0);

    // random phases; the seed is left alone now and then so the
    // generator carries over between data sets
    while (items_queued < ITEM_GOAL) begin
      n = $urandom_range(2, 8);
      k = $urandom_range(1, 3);
      gaps_on = ($urandom_range(0, 3) != 0);
      queue_write(REG_POINT_COUNT, n);
      queue_write(REG_CLUSTER_COUNT, k);
      if ($urandom_range(0, 1)) queue_write(REG_RESTART_COUNT, $urandom_range(1, 4));
      if ($urandom_range(0, 2) == 0) queue_write(REG_RNG_SEED, $urandom);
      queue_write(REG_PASS_LIMIT, $urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 20));
      queue_data_set(n, k, $urandom_range(0, 4) != 0, 1'b0);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (beat_q.size() != 0 || s_axis_tvalid || cfg_valid || label_q.size() != 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
